FILE: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, request codes, status codes and controller states for the
// indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY_DEFAULT   = 32;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int KIND_W  = 3;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 6;

    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PREPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FILL,
        ST_REMOVE,
        ST_READ
    } state_t;

endpackage

FILE: rtl/ile_store.sv
// ----------------------------------------------------------------------------
// ile_store
// Entry memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ile_store #(
    parameter int DEPTH      = ile_pkg::CAPACITY_DEFAULT,
    parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEFAULT,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // During a shift accesses never collide: a shift writes behind the entry it reads.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/indexed_list_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Ordered list of signed values kept in one memory; inserts and removals move
// entries one per cycle through a read-modify-write sweep.
// ----------------------------------------------------------------------------
// Timing: the result strobe rises in the cycle after the accepting edge for
// adds that land at the tail, full-list and range errors, and unknown kinds;
// a read passes through the read state; any other insert moves entries up in
// the insert state, then writes the value in the fill state; remove and pop
// move entries down in the remove state, one per cycle through one write port.
// Throughput: a new request may start the cycle its result is shown.
// The receiver cannot stall; each result is valid for one cycle only.
// Reset clears the list length and the controller; memory contents stay as is.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit #(
    parameter int CAPACITY   = ile_pkg::CAPACITY_DEFAULT,
    parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ile_pkg::KIND_W-1:0]  kind,
    input  logic [ile_pkg::INDEX_W-1:0] index,
    input  logic [ile_pkg::VALUE_W-1:0] value,
    output logic                        done,
    output logic [ile_pkg::VALUE_W-1:0] read_value,
    output logic [ile_pkg::STAT_W-1:0]  status,
    output logic [ile_pkg::LEN_W-1:0]   length
);

    // Address width, count width, and a common width for index comparisons.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW + ile_pkg::LEN_W;
    localparam int VW = ile_pkg::VALUE_W;

    ile_pkg::state_t state_reg, state_next;

    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [ile_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_WIDTH-1:0]  value_reg, value_next;
    logic [DATA_WIDTH-1:0]  hold_reg, hold_next;
    logic                   done_reg, done_next;
    logic [VW-1:0]          rv_reg, rv_next;
    logic [ile_pkg::STAT_W-1:0] stat_reg, stat_next;

    // Memory port signals.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    ile_store #(
        .DEPTH      (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The incoming value keeps its low DATA_WIDTH bits, sign-extended if the
    // storage is wider than the port.
    logic [DATA_WIDTH+VW-1:0] value_ext;
    logic [DATA_WIDTH-1:0]    value_st;
    assign value_ext = {{DATA_WIDTH{value[VW-1]}}, value};
    assign value_st  = value_ext[DATA_WIDTH-1:0];

    // Index decoding. A negative index is out of range for remove and read,
    // and clamps to the front for insert.
    logic          idx_neg;
    logic [EW-1:0] idx_e;
    logic [EW-1:0] cnt_e;
    logic [EW-1:0] ins_e;
    logic          in_range;
    logic          full;
    logic          empty;
    logic [CW-1:0] cnt_m1;

    assign idx_neg  = index[ile_pkg::INDEX_W-1];
    assign idx_e    = EW'(index[ile_pkg::INDEX_W-2:0]);
    assign cnt_e    = EW'(count_reg);
    assign in_range = !idx_neg && (idx_e < cnt_e);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign cnt_m1   = count_reg - CW'(1);

    // Append ignores the index, so it is decided before the clamping.
    always_comb
    begin
        if (kind == ile_pkg::KIND_APPEND)
        begin
            ins_e = cnt_e;
        end
        else if ((kind == ile_pkg::KIND_PREPEND) || idx_neg)
        begin
            ins_e = '0;
        end
        else if (idx_e > cnt_e)
        begin
            ins_e = cnt_e;
        end
        else
        begin
            ins_e = idx_e;
        end
    end

    // Decisions taken when a request is accepted.
    logic accept;
    logic is_place;
    logic is_take;
    logic go_insert;
    logic go_remove;
    logic go_read;

    assign accept    = start && (state_reg == ile_pkg::ST_IDLE);
    assign is_place  = (kind == ile_pkg::KIND_APPEND) || (kind == ile_pkg::KIND_PREPEND)
                       || (kind == ile_pkg::KIND_INSERT);
    assign is_take   = (kind == ile_pkg::KIND_REMOVE) || (kind == ile_pkg::KIND_READ);
    // Inserting at the end needs no shift and is written straight away.
    assign go_insert = accept && is_place && !full && (ins_e != cnt_e);
    assign go_remove = accept && (((kind == ile_pkg::KIND_REMOVE) && in_range)
                       || ((kind == ile_pkg::KIND_POP) && !empty));
    assign go_read   = accept && (kind == ile_pkg::KIND_READ) && in_range;

    // Sweep bookkeeping.
    logic [CW-1:0]        ptr_p1;
    logic                 more_up;
    logic [DATA_WIDTH-1:0] out_data;
    logic [DATA_WIDTH+VW-1:0] out_ext;

    assign ptr_p1  = CW'(ptr_reg) + CW'(1);
    assign more_up = (ptr_p1 < count_reg);
    // On the first cycle of a removal the data just read is the taken entry.
    assign out_data = (ptr_reg == pos_reg) ? mem_rdata : hold_reg;
    assign out_ext  = {{VW{out_data[DATA_WIDTH-1]}}, out_data};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ile_pkg::ST_IDLE:
            begin
                if (go_insert)
                begin
                    state_next = ile_pkg::ST_INSERT;
                end
                else if (go_remove)
                begin
                    state_next = ile_pkg::ST_REMOVE;
                end
                else if (go_read)
                begin
                    state_next = ile_pkg::ST_READ;
                end
            end
            ile_pkg::ST_INSERT:
            begin
                if (ptr_reg == pos_reg)
                begin
                    state_next = ile_pkg::ST_FILL;
                end
            end
            ile_pkg::ST_FILL:
            begin
                state_next = ile_pkg::ST_IDLE;
            end
            ile_pkg::ST_REMOVE:
            begin
                if (!more_up)
                begin
                    state_next = ile_pkg::ST_IDLE;
                end
            end
            ile_pkg::ST_READ:
            begin
                state_next = ile_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ile_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result.
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = value_reg;
        mem_raddr  = ptr_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rv_next    = '0;
        stat_next  = ile_pkg::STAT_OK;

        unique case (state_reg)
            ile_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    value_next = value_st;
                    if (is_place)
                    begin
                        if (full)
                        begin
                            done_next = 1'b1;
                            stat_next = ile_pkg::STAT_FULL;
                        end
                        else if (ins_e == cnt_e)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = value_st;
                            count_next = count_reg + CW'(1);
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            // Start moving entries up from the tail.
                            mem_raddr = cnt_m1[AW-1:0];
                            ptr_next  = cnt_m1[AW-1:0];
                            pos_next  = ins_e[AW-1:0];
                        end
                    end
                    else if (is_take)
                    begin
                        if (!in_range)
                        begin
                            done_next = 1'b1;
                            stat_next = ile_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            mem_raddr = idx_e[AW-1:0];
                            ptr_next  = idx_e[AW-1:0];
                            pos_next  = idx_e[AW-1:0];
                        end
                    end
                    else if (kind == ile_pkg::KIND_POP)
                    begin
                        if (empty)
                        begin
                            done_next = 1'b1;
                            stat_next = ile_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            mem_raddr = '0;
                            ptr_next  = '0;
                            pos_next  = '0;
                        end
                    end
                    else
                    begin
                        // Unknown kinds change nothing.
                        done_next = 1'b1;
                    end
                end
            end
            ile_pkg::ST_INSERT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + AW'(1);
                mem_wdata = mem_rdata;
                if (ptr_reg != pos_reg)
                begin
                    mem_raddr = ptr_reg - AW'(1);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            ile_pkg::ST_FILL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
            end
            ile_pkg::ST_REMOVE:
            begin
                if (ptr_reg == pos_reg)
                begin
                    hold_next = mem_rdata;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (more_up)
                begin
                    mem_raddr = ptr_p1[AW-1:0];
                    ptr_next  = ptr_p1[AW-1:0];
                end
                else
                begin
                    count_next = cnt_m1;
                    done_next  = 1'b1;
                    if (kind_reg == ile_pkg::KIND_POP)
                    begin
                        rv_next = out_ext[VW-1:0];
                    end
                end
            end
            ile_pkg::ST_READ:
            begin
                done_next = 1'b1;
                rv_next   = out_ext[VW-1:0];
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ile_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload and sweep registers.
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        kind_reg  <= kind_next;
        value_reg <= value_next;
        hold_reg  <= hold_next;
        rv_reg    <= rv_next;
        stat_reg  <= stat_next;
    end

    // The length port shows the count after the request, kept to its low bits.
    logic [EW-1:0] len_ext;
    assign len_ext = EW'(count_reg);

    assign busy       = (state_reg != ile_pkg::ST_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign status     = stat_reg;
    assign length     = len_ext[ile_pkg::LEN_W-1:0];

endmodule
